// ----- src/gpss_pkg.sv -----
// Shared types, constants and constant functions of the geodetic pair scale selector.
`default_nettype none
package gpss_pkg;
  localparam int ANGLE_BITS = 32;
  localparam int TRIG_STAGES = 28;
  localparam int SCALE_CELLS = 64;
  localparam int COORD_FRAC = 28;

  localparam logic [63:0] RADIUS_MM = 64'd6378137000;
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam logic signed [63:0] GAIN_Q62 = 64'sd2800459870029452952;

  localparam logic [127:0] RADIUS_PI = {64'd0, RADIUS_MM} * {64'd0, PI_Q61};
  localparam logic [63:0] CIRC_Q28 = RADIUS_PI[95:32];
  localparam logic [127:0] CIRC_SQ = {64'd0, CIRC_Q28} * {64'd0, CIRC_Q28};
  localparam logic [127:0] CIRC_SQ_Q = (CIRC_SQ + 128'd3) >> 2;

  localparam logic [1:0] QUAD_FIRST = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD = 2'd2;

  typedef logic signed [63:0] q62_t;
  typedef logic [127:0] wide_t;

  typedef struct packed {
    q62_t x;
    q62_t y;
    q62_t z;
    logic [1:0] quad;
  } cor_t;

  typedef struct packed {
    logic vld;
    logic done;
    logic [5:0] scale;
    logic clamped;
    wide_t d;
  } scl_t;

  function automatic logic [63:0] floor_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic q62_t atan_q62(input int i);
    q62_t sum;
    int e;
    logic [63:0] term;
    sum = '0;
    if (i == 0) begin
      sum = q62_t'(PI_Q61 >> 1);
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = floor_div(64'd1 << e, 64'(2 * k + 1));
          if ((k & 1) == 1) begin
            sum = sum - q62_t'(term);
          end else begin
            sum = sum + q62_t'(term);
          end
        end
      end
    end
    return sum;
  endfunction
endpackage
`default_nettype wire

// ----- src/gpss_mul.sv -----
// Pipelined signed 64x64 multiplier built from 32x32 partial products, four stages.
`default_nettype none
module gpss_mul (
  input  logic           clk,
  input  gpss_pkg::q62_t a,
  input  gpss_pkg::q62_t b,
  output gpss_pkg::q62_t q62,
  output gpss_pkg::wide_t prod
);
  import gpss_pkg::*;

  logic [63:0] ma_r, mb_r;
  logic [2:0] neg_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  wide_t sum_r;
  logic [62:0] mag;
  q62_t q_r;
  wide_t prod_r;

  assign mag = sum_r[124:62];

  always_ff @(posedge clk) begin
    ma_r <= a[63] ? (64'd0 - 64'(a)) : 64'(a);
    mb_r <= b[63] ? (64'd0 - 64'(b)) : 64'(b);
    neg_r <= {neg_r[1:0], a[63] ^ b[63]};
    p00_r <= {32'd0, ma_r[31:0]} * {32'd0, mb_r[31:0]};
    p01_r <= {32'd0, ma_r[31:0]} * {32'd0, mb_r[63:32]};
    p10_r <= {32'd0, ma_r[63:32]} * {32'd0, mb_r[31:0]};
    p11_r <= {32'd0, ma_r[63:32]} * {32'd0, mb_r[63:32]};
    sum_r <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0} + {p11_r, 64'd0};
    q_r <= neg_r[2] ? (64'sd0 - q62_t'({1'b0, mag})) : q62_t'({1'b0, mag});
    prod_r <= sum_r;
  end

  assign q62 = q_r;
  assign prod = prod_r;
endmodule
`default_nettype wire

// ----- src/gpss_cordic_cell.sv -----
// One rotation cell of the sine and cosine chain.
`default_nettype none
module gpss_cordic_cell (
  input  logic           clk,
  input  logic [5:0]     shift,
  input  gpss_pkg::q62_t atan,
  input  gpss_pkg::cor_t cin,
  output gpss_pkg::cor_t cout
);
  import gpss_pkg::*;

  cor_t cell_r, cell_nxt;
  q62_t xs, ys;

  always_comb begin
    xs = q62_t'(cin.y) >>> shift;
    ys = q62_t'(cin.x) >>> shift;
    cell_nxt = cin;
    if (!cin.z[63]) begin
      cell_nxt.x = cin.x - xs;
      cell_nxt.y = cin.y + ys;
      cell_nxt.z = cin.z - atan;
    end else begin
      cell_nxt.x = cin.x + xs;
      cell_nxt.y = cin.y - ys;
      cell_nxt.z = cin.z + atan;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cout = cell_r;
endmodule
`default_nettype wire

// ----- src/gpss_scale_cell.sv -----
// One step of the scale search: compare against the circumference square and its quarter, else shift left by two bits.
`default_nettype none
module gpss_scale_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [5:0]     idx,
  input  gpss_pkg::scl_t cin,
  output gpss_pkg::scl_t cout
);
  import gpss_pkg::*;

  scl_t cell_r, cell_nxt;

  always_comb begin
    cell_nxt = cin;
    if (!cin.done) begin
      if (cin.d >= CIRC_SQ) begin
        cell_nxt.done = 1'b1;
        cell_nxt.scale = idx;
        cell_nxt.clamped = 1'b0;
      end else if (cin.d >= CIRC_SQ_Q) begin
        cell_nxt.done = 1'b1;
        if (idx != 6'd63) begin
          cell_nxt.scale = idx + 6'd1;
          cell_nxt.clamped = 1'b0;
        end
      end else begin
        cell_nxt.d = cin.d << 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= '0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

  // A request that is still searching keeps the saturated default.
  a_open_default: assert property (@(posedge clk) disable iff (!rst_n)
    cell_r.vld && !cell_r.done |-> cell_r.clamped && cell_r.scale == 6'd63)
    else $error("open search lost its default");

  // A settled request no longer shifts its distance.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cin.done |=> cell_r.d == $past(cin.d))
    else $error("settled distance changed");

  // An unclamped result cannot exceed the next step index.
  a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cell_r.vld && cell_r.done && !cell_r.clamped |-> {1'b0, cell_r.scale} <= {1'b0, idx} + 7'd1)
    else $error("scale beyond cell position");
endmodule
`default_nettype wire

// ----- src/geodetic_pair_scale_select_top.sv -----
// Top level of the geodetic pair scale selector.
// Channel   | Ports                                            | Handshake
// request   | in_vertex_*, in_origin_* (lon, lat, height)      | start high, busy low
// result    | out_scale, out_clamped                           | out_strobe, one cycle
// A request is taken every cycle while busy is low; busy is high during reset and in the first cycle after it.
// The result of a request passes through the rotation chain, four multiplier layers and the
// 64-cell scale search chain.
// Reset is synchronous and clears all valid flags; requests in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module geodetic_pair_scale_select_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vertex_lon,
  input  logic signed [31:0] in_vertex_lat,
  input  logic signed [31:0] in_vertex_height,
  input  logic signed [31:0] in_origin_lon,
  input  logic signed [31:0] in_origin_lat,
  input  logic signed [31:0] in_origin_height,
  output logic               out_strobe,
  output logic [5:0]         out_scale,
  output logic               out_clamped
);
  import gpss_pkg::*;

  localparam int NANG = 4;
  localparam int NPT = 2;
  localparam int NCRD = 3;
  localparam int MAP = TRIG_STAGES + 5;
  localparam int VLEN = MAP + 16;
  localparam int HLEN = TRIG_STAGES + 5;
  localparam int SHL = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
  localparam int SHR = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
  localparam int FSH = 64 - ANGLE_BITS;
  localparam logic [63:0] FRAC_MASK = (64'd1 << (ANGLE_BITS - 2)) - 64'd1;

  logic busy_r;
  logic accept;
  logic [VLEN-1:0] vld_r;
  logic [31:0] ang [NANG];
  logic [63:0] ang_p [NANG];
  logic [1:0] quad_c [NANG];
  q62_t frac_c [NANG];
  q62_t frac_r [NANG];
  logic [1:0] qd_r [5][NANG];
  logic signed [31:0] hd_r [HLEN][NPT];
  q62_t phi [NANG];
  cor_t cor [NANG][TRIG_STAGES+1];
  q62_t cos_c [NANG];
  q62_t sin_c [NANG];
  q62_t rad_c [NPT];
  q62_t sin_lat_r [NPT];
  q62_t cos_lat_r [NPT];
  q62_t rad_r [NPT];
  q62_t sin_lon_r [5][NPT];
  q62_t cos_lon_r [5][NPT];
  q62_t y_q [NPT];
  q62_t rh_q [NPT];
  q62_t yd_r [4][NPT];
  q62_t x_q [NPT];
  q62_t z_q [NPT];
  q62_t df_r [NCRD];
  wide_t sq [NCRD];
  wide_t s01_r, sq2_r, d_r;
  scl_t pre_r, pre_nxt;
  scl_t scl [SCALE_CELLS+1];

  assign accept = start & ~busy_r;
  assign busy = busy_r;

  assign ang[0] = in_vertex_lat;
  assign ang[1] = in_vertex_lon;
  assign ang[2] = in_origin_lat;
  assign ang[3] = in_origin_lon;

  always_comb begin
    for (int a = 0; a < NANG; a++) begin
      ang_p[a] = ({32'd0, ang[a]} << SHL) >> SHR;
      quad_c[a] = ang_p[a][ANGLE_BITS-1 -: 2];
      frac_c[a] = q62_t'((ang_p[a] & FRAC_MASK) << FSH);
    end
  end

  always_comb begin
    for (int a = 0; a < NANG; a++) begin
      case (cor[a][TRIG_STAGES].quad)
        QUAD_FIRST: begin
          cos_c[a] = cor[a][TRIG_STAGES].x;
          sin_c[a] = cor[a][TRIG_STAGES].y;
        end
        QUAD_SECOND: begin
          cos_c[a] = 64'sd0 - cor[a][TRIG_STAGES].y;
          sin_c[a] = cor[a][TRIG_STAGES].x;
        end
        QUAD_THIRD: begin
          cos_c[a] = 64'sd0 - cor[a][TRIG_STAGES].x;
          sin_c[a] = 64'sd0 - cor[a][TRIG_STAGES].y;
        end
        default: begin
          cos_c[a] = cor[a][TRIG_STAGES].y;
          sin_c[a] = 64'sd0 - cor[a][TRIG_STAGES].x;
        end
      endcase
    end
    for (int p = 0; p < NPT; p++) begin
      rad_c[p] = (q62_t'(RADIUS_MM) + q62_t'(hd_r[HLEN-1][p])) <<< COORD_FRAC;
    end
  end

  always_comb begin
    pre_nxt.vld = vld_r[MAP+15];
    pre_nxt.d = d_r;
    pre_nxt.done = 1'b0;
    pre_nxt.scale = 6'd63;
    pre_nxt.clamped = 1'b1;
    if (d_r == '0) begin
      pre_nxt.done = 1'b1;
    end else if ((d_r >> 2) >= CIRC_SQ) begin
      pre_nxt.done = 1'b1;
      pre_nxt.scale = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r <= '0;
      pre_r <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r <= {vld_r[VLEN-2:0], accept};
      pre_r <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_c;
    qd_r[0] <= quad_c;
    for (int k = 1; k < 5; k++) begin
      qd_r[k] <= qd_r[k-1];
    end
    hd_r[0][0] <= in_vertex_height;
    hd_r[0][1] <= in_origin_height;
    for (int k = 1; k < HLEN; k++) begin
      hd_r[k] <= hd_r[k-1];
    end
    for (int p = 0; p < NPT; p++) begin
      sin_lat_r[p] <= sin_c[2*p];
      cos_lat_r[p] <= cos_c[2*p];
      sin_lon_r[0][p] <= sin_c[2*p+1];
      cos_lon_r[0][p] <= cos_c[2*p+1];
      rad_r[p] <= rad_c[p];
    end
    for (int k = 1; k < 5; k++) begin
      sin_lon_r[k] <= sin_lon_r[k-1];
      cos_lon_r[k] <= cos_lon_r[k-1];
    end
    yd_r[0] <= y_q;
    for (int k = 1; k < 4; k++) begin
      yd_r[k] <= yd_r[k-1];
    end
    df_r[0] <= x_q[1] - x_q[0];
    df_r[1] <= yd_r[3][1] - yd_r[3][0];
    df_r[2] <= z_q[1] - z_q[0];
    s01_r <= sq[0] + sq[1];
    sq2_r <= sq[2];
    d_r <= s01_r + sq2_r;
  end

  for (genvar a = 0; a < NANG; a++) begin : g_ang
    gpss_mul u_phi (
      .clk  (clk),
      .a    (frac_r[a]),
      .b    (q62_t'(PI_Q61)),
      .q62  (phi[a]),
      .prod ()
    );
    assign cor[a][0] = {GAIN_Q62, 64'sd0, phi[a], qd_r[4][a]};
    for (genvar j = 0; j < TRIG_STAGES; j++) begin : g_rot
      localparam q62_t ATAN_J = atan_q62(j);
      gpss_cordic_cell u_cell (
        .clk   (clk),
        .shift (6'(j)),
        .atan  (ATAN_J),
        .cin   (cor[a][j]),
        .cout  (cor[a][j+1])
      );
    end
  end

  for (genvar p = 0; p < NPT; p++) begin : g_pt
    gpss_mul u_ma_y (
      .clk  (clk),
      .a    (rad_r[p]),
      .b    (sin_lat_r[p]),
      .q62  (y_q[p]),
      .prod ()
    );
    gpss_mul u_ma_h (
      .clk  (clk),
      .a    (rad_r[p]),
      .b    (cos_lat_r[p]),
      .q62  (rh_q[p]),
      .prod ()
    );
    gpss_mul u_mb_x (
      .clk  (clk),
      .a    (rh_q[p]),
      .b    (sin_lon_r[4][p]),
      .q62  (x_q[p]),
      .prod ()
    );
    gpss_mul u_mb_z (
      .clk  (clk),
      .a    (rh_q[p]),
      .b    (cos_lon_r[4][p]),
      .q62  (z_q[p]),
      .prod ()
    );
  end

  for (genvar c = 0; c < NCRD; c++) begin : g_sq
    gpss_mul u_sq (
      .clk  (clk),
      .a    (df_r[c]),
      .b    (df_r[c]),
      .q62  (),
      .prod (sq[c])
    );
  end

  assign scl[0] = pre_r;
  for (genvar j = 0; j < SCALE_CELLS; j++) begin : g_scl
    gpss_scale_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (6'(j)),
      .cin   (scl[j]),
      .cout  (scl[j+1])
    );
  end

  assign out_strobe = scl[SCALE_CELLS].vld;
  assign out_scale = scl[SCALE_CELLS].scale;
  assign out_clamped = scl[SCALE_CELLS].clamped;
endmodule
`default_nettype wire
